>>> hw/rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// LRU page replacement - shared package
// Sizes, cell handover packet and update broadcast types.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int NUM_FRAMES = 8;
    localparam int PAGE_BITS  = 16;

    localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_W  = FRAME_W;
    localparam int CNT_W   = $clog2(NUM_FRAMES + 1);

    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_FRAMES - 1);

    // fixed port widths
    localparam int CFG_W       = 4;
    localparam int IN_PAGE_W   = 16;
    localparam int OUT_FRAME_W = 3;
    localparam int OUT_PAGE_W  = 16;
    localparam int COUNT_W     = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // packet handed from cell to cell while one reference is looked up
    typedef struct packed {
        logic                 vld;
        logic [PAGE_BITS-1:0] page;
        logic                 hit;
        logic [FRAME_W-1:0]   hit_idx;
        logic [RANK_W-1:0]    hit_rank;
        logic                 empty;
        logic [FRAME_W-1:0]   empty_idx;
        logic                 best_set;
        logic [FRAME_W-1:0]   best_idx;
        logic [RANK_W-1:0]    best_rank;
        logic [PAGE_BITS-1:0] best_page;
    } t_pkt;

    // update broadcast to every cell when a reference is committed
    typedef struct packed {
        logic                 en;
        logic [FRAME_W-1:0]   frame;
        logic [RANK_W-1:0]    old_rank;
        logic                 all_age;
        logic                 fault;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

endpackage

`default_nettype wire

>>> hw/rtl/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement - top level
// Fully associative frame set with least recently used replacement.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one page reference per transfer. The
// reference travels down a row of frame cells, one cell per cycle, gathering
// hit, first empty frame and oldest frame; at the end of the row the decision
// is broadcast back to all cells at once and the result is registered.
// Output channel (o_valid/i_ready) gives one result per reference: fault,
// frame, evicted page and the saturating fault total.
// One reference is looked up at a time: a new reference is accepted the
// cycle after its result is loaded into the output register, so the block
// takes no new reference until the last one has gone through the cell row
// and been committed. The output register holds a result while the
// receiver stalls; the next reference still runs through the row and waits
// at its end until the output register is free.
// Config channel (i_cfg_valid/o_cfg_ready) writes frames_in_use, always
// ready; write it only while the block is idle. Reset empties all frames,
// clears ranks and the fault total and sets frames_in_use to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [lrupr_pkg::IN_PAGE_W-1:0]   i_page_number,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_fault,
    output logic [lrupr_pkg::OUT_FRAME_W-1:0]      o_frame_index,
    output logic                                   o_evicted_valid,
    output logic [lrupr_pkg::OUT_PAGE_W-1:0]       o_evicted_page,
    output logic [lrupr_pkg::COUNT_W-1:0]          o_fault_total,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]       i_cfg_frames_in_use
);

    localparam int N = lrupr_pkg::NUM_FRAMES;

    logic [lrupr_pkg::CFG_W-1:0]     r_cfg;
    logic [lrupr_pkg::CNT_W-1:0]     w_active_cnt;
    logic                            r_busy;
    lrupr_pkg::t_pkt                 r_pend;
    lrupr_pkg::t_pkt                 w_chain [N+1];
    logic [N:0]                      w_chain_vld;
    lrupr_pkg::t_upd                 w_upd;
    logic                            w_accept;
    logic                            w_commit;
    logic [31:0]                     w_in32;
    logic [31:0]                     w_frame32;
    logic [31:0]                     w_ev32;
    logic                            w_evict;
    logic [lrupr_pkg::PAGE_BITS-1:0] w_ev_page;
    logic [lrupr_pkg::COUNT_W-1:0]   r_fault_cnt;
    logic [lrupr_pkg::COUNT_W-1:0]   n_fault_cnt;
    logic                            r_out_valid;
    logic                            r_out_fault;
    logic [lrupr_pkg::OUT_FRAME_W-1:0] r_out_frame;
    logic                            r_out_ev_vld;
    logic [lrupr_pkg::OUT_PAGE_W-1:0] r_out_ev_page;

    // config register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lrupr_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_frames_in_use;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            w_active_cnt = lrupr_pkg::CNT_W'(1);
        end else if (32'(r_cfg) > 32'(N)) begin
            w_active_cnt = lrupr_pkg::CNT_W'(N);
        end else begin
            w_active_cnt = lrupr_pkg::CNT_W'(r_cfg);
        end
    end

    // lookup injection
    assign o_ready  = !r_busy;
    assign w_accept = i_valid && o_ready;
    assign w_in32   = 32'(i_page_number);

    always_comb begin
        w_chain[0]      = '0;
        w_chain[0].vld  = w_accept;
        w_chain[0].page = w_in32[lrupr_pkg::PAGE_BITS-1:0];
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_idx   (lrupr_pkg::FRAME_W'(g)),
            .i_active_cnt (w_active_cnt),
            .i_pkt        (w_chain[g]),
            .i_upd        (w_upd),
            .o_pkt        (w_chain[g+1])
        );
    end

    for (genvar g = 0; g <= N; g++) begin : g_vld
        assign w_chain_vld[g] = w_chain[g].vld;
    end

    // decision at the end of the row
    assign w_commit = r_pend.vld && (!r_out_valid || i_ready);

    always_comb begin
        w_upd          = '0;
        w_upd.en       = w_commit;
        w_upd.page     = r_pend.page;
        w_evict        = 1'b0;
        w_ev_page      = '0;
        if (r_pend.hit) begin
            w_upd.frame    = r_pend.hit_idx;
            w_upd.old_rank = r_pend.hit_rank;
        end else if (r_pend.empty) begin
            w_upd.fault    = 1'b1;
            w_upd.frame    = r_pend.empty_idx;
            w_upd.all_age  = 1'b1;
        end else begin
            w_upd.fault    = 1'b1;
            w_upd.frame    = r_pend.best_idx;
            w_upd.old_rank = r_pend.best_rank;
            w_evict        = 1'b1;
            w_ev_page      = r_pend.best_page;
        end
    end

    assign w_frame32   = 32'(w_upd.frame);
    assign w_ev32      = 32'(w_ev_page);
    assign n_fault_cnt = (r_fault_cnt == '1) ? r_fault_cnt : r_fault_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_commit) begin
                r_busy <= 1'b0;
            end

            if (w_chain[N].vld) begin
                r_pend <= w_chain[N];
            end else if (w_commit) begin
                r_pend.vld <= 1'b0;
            end

            if (w_commit && w_upd.fault) begin
                r_fault_cnt <= n_fault_cnt;
            end

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_fault   <= w_upd.fault;
            r_out_frame   <= w_frame32[lrupr_pkg::OUT_FRAME_W-1:0];
            r_out_ev_vld  <= w_evict;
            r_out_ev_page <= w_ev32[lrupr_pkg::OUT_PAGE_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_fault         = r_out_fault;
    assign o_frame_index   = r_out_frame;
    assign o_evicted_valid = r_out_ev_vld;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_fault_cnt;

    // only one reference in the row at any time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_chain_vld, r_pend.vld}) <= 1)
        else $error("more than one lookup in flight");

    // a hit leaves the fault total alone
    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !w_upd.fault) |=> $stable(r_fault_cnt))
        else $error("fault total moved on a hit");

    // an eviction is always a fault
    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_evicted_valid || o_fault))
        else $error("eviction reported without fault");

    // no new reference while one is still being looked up
    a_busy_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend.vld && !w_commit) |=> !o_ready)
        else $error("input ready while a lookup is pending");

endmodule

`default_nettype wire

>>> hw/rtl/lrupr_cell.sv
// ----------------------------------------------------------------------------
// LRU page replacement - frame cell
// Holds one frame (page, valid, recency rank), folds its state into the
// lookup packet passing through and applies the committed update.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [lrupr_pkg::FRAME_W-1:0] i_cell_idx,
    input  wire logic [lrupr_pkg::CNT_W-1:0]   i_active_cnt,
    input  wire lrupr_pkg::t_pkt               i_pkt,
    input  wire lrupr_pkg::t_upd               i_upd,
    output lrupr_pkg::t_pkt                    o_pkt
);

    logic                              r_valid;
    logic [lrupr_pkg::RANK_W-1:0]      r_rank;
    logic [lrupr_pkg::PAGE_BITS-1:0]   r_page;
    lrupr_pkg::t_pkt                   r_pkt;
    lrupr_pkg::t_pkt                   n_pkt;
    logic                              w_active;
    logic                              w_age;

    assign w_active = 32'(i_cell_idx) < 32'(i_active_cnt);

    always_comb begin
        n_pkt = i_pkt;
        if (w_active) begin
            if (!i_pkt.hit && r_valid && (r_page == i_pkt.page)) begin
                n_pkt.hit      = 1'b1;
                n_pkt.hit_idx  = i_cell_idx;
                n_pkt.hit_rank = r_rank;
            end
            if (!i_pkt.empty && !r_valid) begin
                n_pkt.empty     = 1'b1;
                n_pkt.empty_idx = i_cell_idx;
            end
            // strictly older wins, so ties keep the lower frame
            if (!i_pkt.best_set || (r_rank > i_pkt.best_rank)) begin
                n_pkt.best_set  = 1'b1;
                n_pkt.best_idx  = i_cell_idx;
                n_pkt.best_rank = r_rank;
                n_pkt.best_page = r_page;
            end
        end
    end

    assign w_age = r_valid && (i_upd.all_age || (r_rank < i_upd.old_rank)) &&
                   (r_rank < lrupr_pkg::RANK_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt   <= '0;
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_pkt <= n_pkt;
            if (i_upd.en && w_active) begin
                if (i_upd.frame == i_cell_idx) begin
                    r_valid <= 1'b1;
                    r_rank  <= '0;
                end else if (w_age) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && w_active && i_upd.fault && (i_upd.frame == i_cell_idx)) begin
            r_page <= i_upd.page;
        end
    end

    assign o_pkt = r_pkt;

endmodule

`default_nettype wire

>>> verif/lru_page_replacement_checker.sv
// ----------------------------------------------------------------------------
// LRU page replacement - result checker
// Watches the reference, result and frames_in_use channels, predicts every
// result from its own copy of frames, ranks and fault total, and compares
// each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              o_ready,
    input  wire logic [lrupr_pkg::IN_PAGE_W-1:0]   i_page_number,
    input  wire logic                              o_valid,
    input  wire logic                              i_ready,
    input  wire logic                              o_fault,
    input  wire logic [lrupr_pkg::OUT_FRAME_W-1:0] o_frame_index,
    input  wire logic                              o_evicted_valid,
    input  wire logic [lrupr_pkg::OUT_PAGE_W-1:0]  o_evicted_page,
    input  wire logic [lrupr_pkg::COUNT_W-1:0]     o_fault_total,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              o_cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]       i_cfg_frames_in_use,
    output int                                     fail_count,
    output int                                     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                              fault;
        logic [lrupr_pkg::OUT_FRAME_W-1:0] frame;
        logic                              ev_valid;
        logic [lrupr_pkg::OUT_PAGE_W-1:0]  ev_page;
        logic [lrupr_pkg::COUNT_W-1:0]     total;
    } t_lookup;

    logic [lrupr_pkg::PAGE_BITS-1:0] frame_page  [lrupr_pkg::NUM_FRAMES];
    logic                            frame_valid [lrupr_pkg::NUM_FRAMES];
    logic [lrupr_pkg::RANK_W-1:0]    frame_rank  [lrupr_pkg::NUM_FRAMES];
    logic [lrupr_pkg::COUNT_W-1:0]   faults;
    logic [lrupr_pkg::CFG_W-1:0]     frames_cfg;
    t_lookup                         pending_lookups [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Bring frame f to rank 0; active valid frames younger than limit age by one.
    function automatic void make_newest(input int f, input int n, input int limit);
        for (int i = 0; i < n; i++) begin
            if (i != f && frame_valid[i] && int'(frame_rank[i]) < limit &&
                frame_rank[i] < lrupr_pkg::RANK_MAX)
                frame_rank[i] = frame_rank[i] + 1'b1;
        end
        frame_rank[f] = '0;
    endfunction

    function automatic t_lookup lru_reference(
        input logic [lrupr_pkg::IN_PAGE_W-1:0] page_in);
        t_lookup                         r;
        logic [lrupr_pkg::PAGE_BITS-1:0] page;
        logic                            hit;
        logic                            empty;
        int                              n;
        int                              f;
        int                              best;
        r     = '0;
        page  = page_in[lrupr_pkg::PAGE_BITS-1:0];
        hit   = 1'b0;
        empty = 1'b0;
        f     = 0;
        if (frames_cfg == 0)
            n = 1;
        else if (int'(frames_cfg) > lrupr_pkg::NUM_FRAMES)
            n = lrupr_pkg::NUM_FRAMES;
        else
            n = int'(frames_cfg);

        // lowest-numbered matching frame wins
        for (int i = 0; i < n; i++) begin
            if (!hit && frame_valid[i] && frame_page[i] == page) begin
                hit = 1'b1;
                f   = i;
            end
        end

        if (hit) begin
            make_newest(f, n, int'(frame_rank[f]));
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!empty && !frame_valid[i]) begin
                    empty = 1'b1;
                    f     = i;
                end
            end
            if (empty) begin
                make_newest(f, n, 256);
            end else begin
                // strictly greater keeps the lowest frame on a tie
                best = 0;
                for (int i = 1; i < n; i++) begin
                    if (frame_rank[i] > frame_rank[best])
                        best = i;
                end
                f          = best;
                r.ev_valid = 1'b1;
                r.ev_page  = lrupr_pkg::OUT_PAGE_W'(frame_page[f]);
                make_newest(f, n, int'(frame_rank[f]));
            end
            frame_page[f]  = page;
            frame_valid[f] = 1'b1;
            if (faults != '1)
                faults = faults + 1'b1;
        end

        r.fault = !hit;
        r.frame = lrupr_pkg::OUT_FRAME_W'(f);
        r.total = faults;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup want;
        if (!i_rst_n) begin
            for (int i = 0; i < lrupr_pkg::NUM_FRAMES; i++) begin
                frame_page[i]  = '0;
                frame_valid[i] = 1'b0;
                frame_rank[i]  = '0;
            end
            faults     = '0;
            frames_cfg = lrupr_pkg::CFG_RESET;
            pending_lookups.delete();
        end else begin
            // result transfer first: it always belongs to an older reference
            if (o_valid && i_ready) begin
                if (pending_lookups.size() == 0) begin
                    $display("%0t: unexpected result, actual fault=%0b frame=%0d",
                             $time, o_fault, o_frame_index);
                    fail_count++;
                end else begin
                    want = pending_lookups.pop_front();
                    check_field("fault", 32'(want.fault), 32'(o_fault));
                    check_field("frame_index", 32'(want.frame), 32'(o_frame_index));
                    check_field("evicted_valid", 32'(want.ev_valid),
                                32'(o_evicted_valid));
                    check_field("evicted_page", 32'(want.ev_page), 32'(o_evicted_page));
                    check_field("fault_total", want.total, o_fault_total);
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                frames_cfg = i_cfg_frames_in_use;
            if (i_valid && o_ready)
                pending_lookups.push_back(lru_reference(i_page_number));
        end
        pending_count = pending_lookups.size();
    end

endmodule

`default_nettype wire

>>> verif/tb_lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// LRU page replacement - testbench top
// Drives page references and frames_in_use writes into the block under
// random back-pressure and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lru_page_replacement_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEGMENTS   = 14;
    localparam int SEG_ITEMS  = 120;
    localparam int POOL_MAX   = 12;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 2 * (lrupr_pkg::NUM_FRAMES + 2);

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [lrupr_pkg::IN_PAGE_W-1:0]   i_page_number = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic                              o_fault;
    logic [lrupr_pkg::OUT_FRAME_W-1:0] o_frame_index;
    logic                              o_evicted_valid;
    logic [lrupr_pkg::OUT_PAGE_W-1:0]  o_evicted_page;
    logic [lrupr_pkg::COUNT_W-1:0]     o_fault_total;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [lrupr_pkg::CFG_W-1:0]       i_cfg_frames_in_use = '0;

    int fail_count;
    int pending_count;
    int send_idle_pct = 23;
    int recv_idle_pct = 73;
    int idle_cycles = 0;

    lru_page_replacement_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_page_number      (i_page_number),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_fault            (o_fault),
        .o_frame_index      (o_frame_index),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_page     (o_evicted_page),
        .o_fault_total      (o_fault_total),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_frames_in_use(i_cfg_frames_in_use)
    );

    lru_page_replacement_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_page_number      (i_page_number),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_fault            (o_fault),
        .o_frame_index      (o_frame_index),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_page     (o_evicted_page),
        .o_fault_total      (o_fault_total),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_frames_in_use(i_cfg_frames_in_use),
        .fail_count         (fail_count),
        .pending_count      (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_page(input logic [lrupr_pkg::IN_PAGE_W-1:0] page);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // hold the sender off until every outstanding result has been taken
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic write_frames_in_use(input logic [lrupr_pkg::CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid         <= 1'b1;
        i_cfg_frames_in_use <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [lrupr_pkg::IN_PAGE_W-1:0] page_pool [POOL_MAX];
        logic [lrupr_pkg::CFG_W-1:0]     cfg_value;
        int                              pool_size;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fill, hit, evict oldest, all with reset frames_in_use
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h8000);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'h1234);
        send_page(16'h7FFF);
        send_page(16'hFFFF);
        send_page(16'h0F0F);
        send_page(16'h0000);
        // page resident above the active range misses, then duplicates appear
        write_frames_in_use(4'd2);
        send_page(16'h1234);
        send_page(16'h1234);
        write_frames_in_use(4'd8);
        send_page(16'h1234);
        send_page(16'h4321);
        send_page(16'h5555);
        // zero means one frame, above the frame count saturates
        write_frames_in_use(4'd0);
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        write_frames_in_use(4'd15);
        send_page(16'h7FFF);
        send_page(16'hC3C3);
        send_page(16'h0F0F);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 5) begin
                send_idle_pct = 73;
                recv_idle_pct = 23;
            end else if (seg == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: cfg_value = 4'd1;
                1: cfg_value = 4'd15;
                2: cfg_value = 4'd0;
                3: cfg_value = 4'd8;
                default: cfg_value = lrupr_pkg::CFG_W'($urandom_range(15));
            endcase
            write_frames_in_use(cfg_value);

            // small working set so hits, refills and evictions all occur
            pool_size = $urandom_range(1, POOL_MAX);
            for (int i = 0; i < POOL_MAX; i++)
                page_pool[i] = lrupr_pkg::IN_PAGE_W'($urandom);

            for (int k = 0; k < SEG_ITEMS; k++) begin
                if (k == SEG_ITEMS / 2)
                    wait_drained();
                if ($urandom_range(99) < 75)
                    send_page(page_pool[$urandom_range(pool_size - 1)]);
                else
                    send_page(lrupr_pkg::IN_PAGE_W'($urandom));
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
